// ===== hdl/mctp_pkg.sv =====
// Shared types, constants and command codes of the multi-channel timer pool.
// Depends on nothing; mctp_ctrl, the top level and the checker import it.
package mctp_pkg;

   // Number of channels built; the channel fields are 3 bits, so at most eight are used.
   localparam int TIMER_COUNT = 8;
   localparam int POOL_SIZE   = (TIMER_COUNT < 8) ? TIMER_COUNT : 8;
   localparam int ADDR_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int RAM_DEPTH   = 1 << ADDR_W;

   localparam logic [15:0] TICKS_PER_SECOND = 16'd1000;

   // floor(t / 1000) == (t * RECIP_1000) >> RECIP_SHIFT for every 16-bit t.
   localparam logic [16:0] RECIP_1000  = 17'd67109;
   localparam int          RECIP_SHIFT = 26;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [3:0] {
      CMD_TICK,
      CMD_CHECK,
      CMD_ADD_ONCE,
      CMD_ADD_LONG,
      CMD_ADD_LOOP,
      CMD_CREATE,
      CMD_RESTART,
      CMD_STOP,
      CMD_PAUSE,
      CMD_RESUME,
      CMD_DELETE,
      CMD_QUERY,
      CMD_RESET_ALL
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_FREE,
      MODE_RUN,
      MODE_STOP,
      MODE_PAUSE
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic        loop;
      logic [15:0] seconds;
      logic [15:0] period;
      logic [15:0] ticks;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        last;
      logic [15:0] seconds_left;
      logic [15:0] ticks_left;
      logic        fired;
      logic [2:0]  channel;
      logic        status;
   } rsp_word_type;

   typedef struct packed {
      logic         push;
      rsp_word_type word;
   } rsp_push_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WALK,
      ST_APPLY,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/mctp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; used for the channel table of the timer pool.
module mctp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mctp_ctrl.sv =====
// Command sequencer of the timer pool: decodes commands, walks the channel table
// for tick and check, and does read-modify-write on single channels. Uses mctp_pkg.
module mctp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [3:0]                      req_tuser,
   input  logic [mctp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            ram_wr_en,
   output logic [mctp_pkg::ADDR_W-1:0]     ram_wr_addr,
   output logic [mctp_pkg::ENTRY_W-1:0]    ram_wr_data,
   output logic                            ram_rd_en,
   output logic [mctp_pkg::ADDR_W-1:0]     ram_rd_addr,
   input  logic [mctp_pkg::ENTRY_W-1:0]    ram_rd_data,
   input  logic                            out_free,
   output mctp_pkg::rsp_push_type          rsp_push
);

   import mctp_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_CH  = ADDR_W'(POOL_SIZE - 1);
   localparam logic [3:0]        POOL_LIM = 4'(POOL_SIZE);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff;
   logic [2:0]           idx_ff;
   logic [15:0]          ms_ff, secs_ff;
   logic [RAM_DEPTH-1:0] busy_ff, busy_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [2:0]           pend_ch_ff, pend_ch_in;
   logic [ADDR_W-1:0]    cur_ff, cur_in;

   logic                 accept;
   logic                 is_walk;
   logic                 in_range;
   logic [ADDR_W-1:0]    idx_addr;
   logic [ADDR_W-1:0]    mask_addr;
   entry_type            cur_e;
   logic                 free_found;
   logic [ADDR_W-1:0]    free_addr;

   entry_type            walk_e;
   logic                 walk_fire;
   logic [15:0]          sec_dec;
   logic                 advance;

   entry_type            apply_e;
   logic                 apply_wr;
   logic [ADDR_W-1:0]    apply_addr;
   logic [RAM_DEPTH-1:0] apply_busy;
   rsp_word_type         apply_word;
   logic                 apply_ok;
   logic                 add_bad;
   logic [32:0]          query_prod;
   logic [15:0]          query_secs;

   rsp_word_type         fire_word;
   rsp_word_type         finish_word;

   assign accept    = req_tvalid && req_tready;
   assign is_walk   = (cmd_ff == CMD_TICK) || (cmd_ff == CMD_CHECK);
   assign in_range  = {1'b0, idx_ff} < POOL_LIM;
   assign idx_addr  = idx_ff[ADDR_W-1:0];
   assign mask_addr = (state_ff == ST_WALK) ? cur_ff : idx_addr;
   // A free channel always reads as all zeros: its stale RAM contents are masked off.
   assign cur_e     = busy_ff[mask_addr] ? entry_type'(ram_rd_data) : '0;

   always_comb begin
      free_found = 1'b0;
      free_addr  = '0;
      for (int i = POOL_SIZE - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_addr  = ADDR_W'(i);
         end
      end
   end

   // One channel of a tick or check walk.
   always_comb begin
      walk_e    = cur_e;
      walk_fire = 1'b0;
      sec_dec   = cur_e.seconds - 16'd1;
      if (cmd_ff == CMD_TICK) begin
         if (cur_e.mode == MODE_RUN && cur_e.ticks != 16'd0) begin
            walk_e.ticks = cur_e.ticks - 16'd1;
         end
      end else if (cur_e.mode == MODE_RUN && cur_e.ticks == 16'd0) begin
         if (cur_e.seconds != 16'd0) begin
            walk_e.seconds = sec_dec;
            walk_e.ticks   = (sec_dec != 16'd0) ? TICKS_PER_SECOND : cur_e.period;
         end else begin
            walk_fire = 1'b1;
            if (cur_e.loop) begin
               walk_e.ticks = cur_e.period;
            end else begin
               walk_e.mode = MODE_STOP;
            end
         end
      end
   end

   assign advance = !(walk_fire && pend_valid_ff && !out_free);

   always_comb begin
      fire_word         = '0;
      fire_word.channel = pend_ch_ff;
      fire_word.fired   = 1'b1;
      finish_word       = '0;
      finish_word.last  = 1'b1;
      if (cmd_ff == CMD_CHECK && pend_valid_ff) begin
         finish_word.channel = pend_ch_ff;
         finish_word.fired   = 1'b1;
      end
   end

   assign query_prod = {17'd0, cur_e.ticks} * {16'd0, RECIP_1000};
   assign query_secs = cur_e.seconds + 16'(query_prod[32:RECIP_SHIFT]);

   // Single-channel commands, and reset_all, which frees every channel.
   always_comb begin
      apply_e            = cur_e;
      apply_wr           = 1'b0;
      apply_addr         = idx_addr;
      apply_busy         = busy_ff;
      apply_ok           = 1'b0;
      add_bad            = 1'b0;
      apply_word         = '0;
      apply_word.last    = 1'b1;
      apply_word.channel = idx_ff;
      case (cmd_ff)
         CMD_ADD_ONCE, CMD_ADD_LONG, CMD_ADD_LOOP, CMD_CREATE: begin
            apply_word.channel = '0;
            add_bad = (cmd_ff == CMD_ADD_LONG) ? (ms_ff == 16'd0 && secs_ff == 16'd0)
                                               : (ms_ff == 16'd0);
            if (add_bad || !free_found) begin
               apply_word.status = 1'b1;
            end else begin
               apply_wr           = 1'b1;
               apply_addr         = free_addr;
               apply_e.mode       = (cmd_ff == CMD_CREATE) ? MODE_STOP : MODE_RUN;
               apply_e.loop       = (cmd_ff == CMD_ADD_LOOP);
               apply_e.seconds    = (cmd_ff == CMD_ADD_LONG) ? secs_ff : 16'd0;
               apply_e.period     = ms_ff;
               if (cmd_ff == CMD_CREATE) begin
                  apply_e.ticks = 16'd0;
               end else if (cmd_ff == CMD_ADD_LONG && ms_ff == 16'd0) begin
                  apply_e.ticks = TICKS_PER_SECOND;
               end else begin
                  apply_e.ticks = ms_ff;
               end
               apply_busy[free_addr] = 1'b1;
               apply_word.channel    = 3'(free_addr);
            end
         end
         CMD_RESTART: begin
            apply_ok = in_range && cur_e.mode != MODE_FREE;
            if (apply_ok) begin
               apply_wr      = 1'b1;
               apply_e.ticks = cur_e.period;
               apply_e.mode  = MODE_RUN;
            end
            apply_word.status = !apply_ok;
         end
         CMD_STOP: begin
            apply_ok = in_range && (cur_e.mode inside {MODE_RUN, MODE_PAUSE});
            if (apply_ok) begin
               apply_wr      = 1'b1;
               apply_e.ticks = 16'd0;
               apply_e.mode  = MODE_STOP;
            end
            apply_word.status = !apply_ok;
         end
         CMD_PAUSE: begin
            apply_ok = in_range && cur_e.mode == MODE_RUN;
            if (apply_ok) begin
               apply_wr     = 1'b1;
               apply_e.mode = MODE_PAUSE;
            end
            apply_word.status = !apply_ok;
         end
         CMD_RESUME: begin
            apply_ok = in_range && cur_e.mode == MODE_PAUSE;
            if (apply_ok) begin
               apply_wr     = 1'b1;
               apply_e.mode = MODE_RUN;
            end
            apply_word.status = !apply_ok;
         end
         CMD_DELETE: begin
            if (in_range) begin
               apply_busy[idx_addr] = 1'b0;
            end
            apply_word.status = !in_range;
         end
         CMD_QUERY: begin
            if (in_range) begin
               apply_word.ticks_left   = cur_e.ticks;
               apply_word.seconds_left = query_secs;
            end else begin
               apply_word.status = 1'b1;
            end
         end
         CMD_RESET_ALL: begin
            apply_busy         = '0;
            apply_word.channel = '0;
         end
         default: begin
            apply_word.status  = 1'b1;
            apply_word.channel = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = is_walk ? ST_WALK : ST_APPLY;
         end
         ST_WALK: begin
            if (advance && cur_ff == LAST_CH) state_in = ST_FINISH;
         end
         ST_APPLY, ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready    = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      rsp_push      = '0;
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      cur_in        = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_READ: begin
            ram_rd_en     = 1'b1;
            ram_rd_addr   = is_walk ? '0 : idx_addr;
            cur_in        = '0;
            pend_valid_in = 1'b0;
         end
         ST_WALK: begin
            if (advance) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff;
               ram_wr_data = walk_e;
               if (walk_fire) begin
                  // A held fire is released only once a later one proves it is not last.
                  if (pend_valid_ff) begin
                     rsp_push.push = 1'b1;
                     rsp_push.word = fire_word;
                  end
                  pend_valid_in = 1'b1;
                  pend_ch_in    = 3'(cur_ff);
               end
               if (cur_ff != LAST_CH) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = cur_ff + ADDR_W'(1);
                  cur_in      = cur_ff + ADDR_W'(1);
               end
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               rsp_push.push = 1'b1;
               rsp_push.word = apply_word;
               ram_wr_en     = apply_wr;
               ram_wr_addr   = apply_addr;
               ram_wr_data   = apply_e;
               busy_in       = apply_busy;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_push.push = 1'b1;
               rsp_push.word = finish_word;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         pend_valid_ff <= 1'b0;
         cur_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         cur_ff        <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ch_ff <= pend_ch_in;
      if (accept) begin
         cmd_ff  <= cmd_type'(req_tuser);
         idx_ff  <= req_tdata[2:0];
         ms_ff   <= req_tdata[18:3];
         secs_ff <= req_tdata[34:19];
      end
   end

endmodule

// ===== hdl/multi_channel_timer_pool.sv =====
// Top level of the multi-channel timer pool: channel table RAM, command sequencer
// and the result output register. Uses mctp_pkg, mctp_ram and mctp_ctrl.
//
// Usage: one command word enters on the req_ channel; tuser carries the command
// code, tdata the channel index, the period in milliseconds and the seconds count.
// Every command returns one result word on the rsp_ channel, except a check that
// fires channels, which returns one word per fired channel in channel order.
// rsp_tlast marks the final word of a command and rsp_tuser marks a fire report.
// Channel state lives in a single RAM with a registered read. A tick or a check
// reads and writes back one channel per cycle unless it stalls on a fire report.
// Every other command reads its channel, modifies it and writes any change back.
// The result register lets a new command be taken while the last word waits; if
// the receiver holds rsp_tready low, a walk stops on the next fire it has to emit
// and single-channel commands wait before writing back, so nothing is lost.
// After reset all channels read as free and zero: a busy bit per channel masks
// the RAM contents, so no clearing pass is needed, and reset_all works the same way.
module multi_channel_timer_pool (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [3:0]                      req_tuser,  // command
   // req_tdata from bit 0: timer_index[2:0], milliseconds[15:0], seconds[15:0], zero pad
   input  logic [mctp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_tuser,  // fired
   // rsp_tdata from bit 0: status, channel[2:0], ticks_left[15:0], seconds_left[15:0], zero pad
   output logic [mctp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   import mctp_pkg::*;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic                out_free;
   rsp_push_type        rsp_push;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   mctp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mctp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .rsp_push    (rsp_push)
   );

   // The output register can take a new word when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_push.push) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = rsp_push.word;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_word_ff.fired;
   assign rsp_tlast  = rsp_word_ff.last;
   assign rsp_tdata  = {4'd0, rsp_word_ff.seconds_left, rsp_word_ff.ticks_left,
                        rsp_word_ff.channel, rsp_word_ff.status};

endmodule

// ===== hdl/mctp_checker.sv =====
// Port-level checks of the timer pool and the bind that attaches them to the top level.
// Uses mctp_pkg for the bus widths.
module mctp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            rsp_tuser,
   input logic [mctp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   import mctp_pkg::*;

   // A result word stays offered, unchanged, until it is taken.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                                  $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word withdrawn or changed before it was taken");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   // After an accept the sequencer leaves its idle state, so the block is busy right after an accept.
   assert property (@(posedge clock) disable iff (reset)
                    req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted on two consecutive cycles");

   // A fire report is always an accepted word without query data.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tuser |-> !rsp_tdata[0] && rsp_tdata[35:4] == 32'd0)
      else $error("fire report carries status or query data");

endmodule

bind multi_channel_timer_pool mctp_checker u_checker (.*);
